// File: rtl/core/shuffled_lcg_random_range_defines.svh
// Assertion macros shared by the RTL. Every check is clocked on clk
// and held off while rst is high.
`ifndef SHUFFLED_LCG_RANDOM_RANGE_DEFINES_SVH
`define SHUFFLED_LCG_RANDOM_RANGE_DEFINES_SVH

// Same-cycle implication.
`define SLRR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SLRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/slrr_pkg.sv
package slrr_pkg;

  localparam logic [14:0] LCG_MUL  = 15'd16807;
  localparam logic [30:0] LCG_MOD  = 31'h7FFF_FFFF;
  localparam logic [31:0] RAND_TOP = 32'h7FFF_FFFF;
  localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LIMIT,
    ST_SEED,
    ST_WARM_MUL,
    ST_WARM_FOLD,
    ST_DRAW_MUL,
    ST_DRAW_FOLD,
    ST_DRAW_SLOT,
    ST_DRAW_SWAP,
    ST_CHECK,
    ST_MOD,
    ST_FINISH
  } slrr_state_t;

  typedef struct packed {
    logic req_load;
    logic seed_load;
    logic div_start;
    logic div_sel_draw;
    logic limit_load;
    logic lcg_seed;
    logic warm_fold;
    logic draw_fold;
    logic slot_start;
    logic tbl_rd;
    logic swap;
    logic out_load;
  } slrr_cmd_t;

  typedef struct packed {
    logic kind;
    logic span_zero;
    logic div_busy;
    logic slot_busy;
    logic warm_last;
    logic reject;
  } slrr_status_t;

endpackage

// File: rtl/core/slrr_mod_div.sv
module slrr_mod_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] remainder
);

  logic [5:0]  cnt;
  logic [31:0] dvd;
  logic [31:0] rem;
  logic [32:0] trial;
  logic [32:0] diff;

  // Restoring division, one quotient bit per cycle; only the remainder is kept.
  assign trial = {rem, dvd[31]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 6'd0;
    end else if (start) begin
      cnt <= 6'd32;
    end else if (cnt != 6'd0) begin
      cnt <= cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 32'd0;
      dvd <= dividend;
    end else if (cnt != 6'd0) begin
      dvd <= {dvd[30:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= diff[31:0];
      end else begin
        rem <= trial[31:0];
      end
    end
  end

  assign busy      = (cnt != 6'd0);
  assign remainder = rem;

endmodule

// File: rtl/core/slrr_datapath.sv
module slrr_datapath #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 kind,
  input  logic signed [31:0]   range_low,
  input  logic signed [31:0]   range_high,
  input  logic [30:0]          seed,
  input  slrr_pkg::slrr_cmd_t  cmd,
  output slrr_pkg::slrr_status_t st,
  output logic signed [31:0]   value
);
  import slrr_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 8);
  localparam int RW    = IDX_W + 1;
  localparam logic [31:0]   SLOT_DIV   = 32'(1 + (2147483646 / TABLE_DEPTH));
  localparam logic [RW-1:0] SLOT_RECIP = RW'(64'h8000_0000 / {32'd0, SLOT_DIV});

  logic [30:0]          seed_r;
  logic                 kind_r;
  logic signed [31:0]   lo_r;
  logic signed [31:0]   hi_r;
  logic [30:0]          lcg;
  logic [45:0]          prod;
  logic [31:0]          fold_sum;
  logic [30:0]          fold_val;
  logic [30:0]          shuffle_out;
  logic [31:0]          limit;
  logic [31:0]          span;
  logic [30+RW:0]       est_prod;
  logic [IDX_W-1:0]     slot_est;
  logic [30:0]          slot_x;
  logic [31:0]          est_base;
  logic [31:0]          est_rem;
  logic                 slot_pend;
  logic [IDX_W-1:0]     slot_q;
  logic [CW-1:0]        warm_cnt;
  logic [30:0]          tbl [TABLE_DEPTH];
  logic [30:0]          rd_data;
  logic                 tbl_we;
  logic [IDX_W-1:0]     tbl_wa;
  logic [30:0]          tbl_wd;
  logic [31:0]          div_dvd;
  logic                 div_busy;
  logic [31:0]          div_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_r <= 31'd0;
    end else if (cmd.seed_load) begin
      seed_r <= seed;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      kind_r <= kind;
      lo_r   <= range_low;
      hi_r   <= range_high;
    end
  end

  assign span = $unsigned(hi_r) - $unsigned(lo_r) + 32'd1;

  // Modulus is 2^31-1, so reduce by folding the high bits back in.
  always_comb begin
    fold_sum = {1'b0, prod[30:0]} + {17'd0, prod[45:31]};
    if (fold_sum >= {1'b0, LCG_MOD}) begin
      fold_val = 31'(fold_sum - {1'b0, LCG_MOD});
    end else begin
      fold_val = fold_sum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= {15'd0, lcg} * {31'd0, LCG_MUL};
    if (cmd.lcg_seed) begin
      if (seed_r == 31'd0 || seed_r == LCG_MOD) begin
        lcg <= 31'd1;
      end else begin
        lcg <= seed_r;
      end
    end else if (cmd.warm_fold || cmd.draw_fold) begin
      lcg <= fold_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lcg_seed) begin
      warm_cnt <= CW'(TABLE_DEPTH + 7);
    end else if (cmd.warm_fold) begin
      warm_cnt <= warm_cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.warm_fold && warm_cnt == CW'(0)) begin
      shuffle_out <= fold_val;
    end else if (cmd.swap) begin
      shuffle_out <= rd_data;
    end
  end

  // Slot index: shuffle_out over a constant by reciprocal multiply, then one
  // compare and subtract, since the estimate is low by at most one.
  assign est_prod = {{RW{1'b0}}, shuffle_out} * {31'd0, SLOT_RECIP};
  assign est_base = {{(32-IDX_W){1'b0}}, slot_est} * SLOT_DIV;
  assign est_rem  = {1'b0, slot_x} - est_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_pend <= 1'b0;
    end else begin
      slot_pend <= cmd.slot_start;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.slot_start) begin
      slot_x   <= shuffle_out;
      slot_est <= est_prod[30+IDX_W:31];
    end
    if (slot_pend) begin
      slot_q <= slot_est + {{(IDX_W-1){1'b0}}, (est_rem >= SLOT_DIV)};
    end
  end

  always_comb begin
    tbl_we = (cmd.warm_fold && warm_cnt < CW'(TABLE_DEPTH)) || cmd.swap;
    if (cmd.swap) begin
      tbl_wa = slot_q;
      tbl_wd = lcg;
    end else begin
      tbl_wa = warm_cnt[IDX_W-1:0];
      tbl_wd = fold_val;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl[tbl_wa] <= tbl_wd;
    end
    if (cmd.tbl_rd) begin
      rd_data <= tbl[slot_q];
    end
  end

  assign div_dvd = cmd.div_sel_draw ? {1'b0, shuffle_out} : HALF_RANGE;

  slrr_mod_div u_mod_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (span),
    .busy      (div_busy),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.limit_load) begin
      limit <= RAND_TOP - div_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (!kind_r) begin
        value <= $signed({1'b0, shuffle_out});
      end else if (span == 32'd0) begin
        value <= lo_r;
      end else begin
        value <= $signed($unsigned(lo_r) + div_rem);
      end
    end
  end

  always_comb begin
    st.kind      = kind_r;
    st.span_zero = (span == 32'd0);
    st.div_busy  = div_busy;
    st.slot_busy = slot_pend;
    st.warm_last = (warm_cnt == CW'(0));
    st.reject    = ({1'b0, shuffle_out} > limit);
  end

endmodule

// File: rtl/core/slrr_ctrl.sv
`include "shuffled_lcg_random_range_defines.svh"

module slrr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  input  logic                   seed_valid,
  output logic                   seed_ready,
  input  slrr_pkg::slrr_status_t st,
  output slrr_pkg::slrr_cmd_t    cmd
);
  import slrr_pkg::*;

  slrr_state_t state;
  slrr_state_t state_next;
  logic        init_pending;
  logic        init_pending_next;
  logic        rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      init_pending <= 1'b1;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      init_pending <= init_pending_next;
      rsp_valid    <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next        = state;
    init_pending_next = init_pending;
    cmd               = '0;
    req_stall         = 1'b1;
    seed_ready        = 1'b0;

    case (state)
      ST_IDLE: begin
        req_stall  = 1'b0;
        seed_ready = 1'b1;
        if (seed_valid) begin
          cmd.seed_load     = 1'b1;
          init_pending_next = 1'b1;
        end
        if (req_valid) begin
          cmd.req_load = 1'b1;
          state_next   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!st.kind) begin
          state_next = init_pending ? ST_SEED : ST_DRAW_MUL;
        end else if (st.span_zero) begin
          state_next = ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_LIMIT;
        end
      end
      ST_LIMIT: begin
        if (!st.div_busy) begin
          cmd.limit_load = 1'b1;
          state_next     = init_pending ? ST_SEED : ST_DRAW_MUL;
        end
      end
      ST_SEED: begin
        cmd.lcg_seed = 1'b1;
        state_next   = ST_WARM_MUL;
      end
      ST_WARM_MUL: begin
        state_next = ST_WARM_FOLD;
      end
      ST_WARM_FOLD: begin
        cmd.warm_fold = 1'b1;
        if (st.warm_last) begin
          init_pending_next = 1'b0;
          state_next        = ST_DRAW_MUL;
        end else begin
          state_next = ST_WARM_MUL;
        end
      end
      ST_DRAW_MUL: begin
        cmd.slot_start = 1'b1;
        state_next     = ST_DRAW_FOLD;
      end
      ST_DRAW_FOLD: begin
        cmd.draw_fold = 1'b1;
        state_next    = ST_DRAW_SLOT;
      end
      ST_DRAW_SLOT: begin
        if (!st.slot_busy) begin
          cmd.tbl_rd = 1'b1;
          state_next = ST_DRAW_SWAP;
        end
      end
      ST_DRAW_SWAP: begin
        cmd.swap   = 1'b1;
        state_next = st.kind ? ST_CHECK : ST_FINISH;
      end
      ST_CHECK: begin
        // drop draws above the limit so every residue is equally likely
        if (st.reject) begin
          state_next = ST_DRAW_MUL;
        end else begin
          cmd.div_start    = 1'b1;
          cmd.div_sel_draw = 1'b1;
          state_next       = ST_MOD;
        end
      end
      ST_MOD: begin
        if (!st.div_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold the result until the output register frees up
        if (!rsp_valid || !rsp_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.out_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
  end

  `SLRR_ASSERT_IMP(a_out_load_free, cmd.out_load, !(rsp_valid && rsp_stall), "result overwritten while held")
  `SLRR_ASSERT_IMP(a_draw_after_init, state == ST_DRAW_MUL, !init_pending, "draw before table warm-up")
  `SLRR_ASSERT_NEXT(a_seed_reinit, cmd.seed_load, init_pending, "seed write did not request warm-up")
  `SLRR_ASSERT_IMP(a_finish_quiet, state == ST_FINISH, !st.div_busy && !st.slot_busy, "finish with unit busy")

endmodule

// File: rtl/core/shuffled_lcg_random_range.sv
// Shuffled minimal-standard random generator with unbiased ranged draws.
// Request channel (req_valid/req_stall): kind, range_low, range_high; a beat is
// taken when req_valid is high and req_stall is low. Response channel
// (rsp_valid/rsp_stall): value, held steady while rsp_stall is high.
// Seed channel (seed_valid/seed_ready): write only while no request is in flight.
// Steps from accept to result valid:
//   raw draw: one draw step (multiply, fold, slot, swap).
//   first draw after reset or a seed write: plus a warm-up of TABLE_DEPTH + 8
//   generator steps (multiply, fold) that fills the shuffle table.
//   ranged draw: plus the rejection limit, a check and the final modulo, both
//   on one bit-serial 32-bit remainder unit, plus a draw step and a check per
//   rejected draw. A zero span returns range_low without a draw.
// One request is worked on at a time, so no beat is taken before the last
// one's result is done; the next is taken as soon as the result sits in
// the output register, even if the receiver holds rsp_stall.
// Reset clears the seed to 0 (the generator then starts from 1) and arms the
// warm-up; the shuffle table needs no clearing.
module shuffled_lcg_random_range #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic               kind,
  input  logic signed [31:0] range_low,
  input  logic signed [31:0] range_high,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] value,
  input  logic               seed_valid,
  output logic               seed_ready,
  input  logic [30:0]        seed
);
  import slrr_pkg::*;

  slrr_cmd_t    cmd;
  slrr_status_t st;

  slrr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .seed_valid (seed_valid),
    .seed_ready (seed_ready),
    .st         (st),
    .cmd        (cmd)
  );

  slrr_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .kind       (kind),
    .range_low  (range_low),
    .range_high (range_high),
    .seed       (seed),
    .cmd        (cmd),
    .st         (st),
    .value      (value)
  );

endmodule

// File: sim/shuffled_lcg_random_range_tb.sv
module shuffled_lcg_random_range_tb;

  localparam logic        KIND_RAW   = 1'b0;
  localparam logic        KIND_RANGE = 1'b1;
  localparam int unsigned TBL_DEPTH  = 32;
  localparam logic [63:0] MULTIPLIER = 64'd16807;
  localparam logic [63:0] MODULUS    = 64'd2147483647;
  localparam logic [30:0] SLOT_SPAN  = 31'(1 + (MODULUS - 1) / TBL_DEPTH);
  localparam int          HOLD_AT    = 60;
  localparam int          HOLD_LEN   = 400;
  localparam int          PHASE_LEN  = 65;

  typedef struct packed {
    logic        kind;
    logic [31:0] lo;
    logic [31:0] hi;
  } draw_req_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic               kind = KIND_RAW;
  logic signed [31:0] range_low = '0;
  logic signed [31:0] range_high = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic signed [31:0] value;
  logic               seed_valid = 1'b0;
  logic               seed_ready;
  logic [30:0]        seed_word = '0;

  // generator copy kept in step with the block
  logic [30:0] gen_seed = '0;
  logic [30:0] gen_state = '0;
  logic [30:0] gen_out = '0;
  logic [30:0] gen_table [TBL_DEPTH];
  logic        gen_reseed = 1'b1;

  draw_req_t   pending_reqs[$];
  logic [31:0] expected_values[$];
  int          errors = 0;
  int          beats_in = 0;
  logic        req_went = 1'b0;
  logic        tx_idle_on = 1'b1;
  logic        rx_idle_on = 1'b1;
  int          tx_gap = 0;
  int          rx_gap = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;

  shuffled_lcg_random_range uut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .kind       (kind),
    .range_low  (range_low),
    .range_high (range_high),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .value      (value),
    .seed_valid (seed_valid),
    .seed_ready (seed_ready),
    .seed       (seed_word)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [30:0] lcg_step(logic [30:0] x);
    logic [63:0] prod;
    prod = {33'd0, x} * MULTIPLIER;
    return 31'(prod % MODULUS);
  endfunction

  function automatic logic [30:0] next_shuffled();
    logic [30:0] x;
    int unsigned slot;
    if (gen_reseed) begin
      x = gen_seed;
      if (x == 31'd0 || x == 31'h7FFF_FFFF) x = 31'd1;
      // eight throwaway steps, then fill the table from the top slot down
      for (int i = TBL_DEPTH + 7; i >= 0; i--) begin
        x = lcg_step(x);
        if (i < TBL_DEPTH) gen_table[i] = x;
      end
      gen_state = x;
      gen_out = gen_table[0];
      gen_reseed = 1'b0;
    end
    gen_state = lcg_step(gen_state);
    slot = gen_out / SLOT_SPAN;
    if (slot >= TBL_DEPTH) slot = TBL_DEPTH - 1;
    gen_out = gen_table[slot];
    gen_table[slot] = gen_state;
    return gen_out;
  endfunction

  function automatic logic [31:0] predict_value(draw_req_t r);
    logic [31:0] span;
    logic [31:0] limit;
    logic [31:0] n;
    if (r.kind == KIND_RAW) return {1'b0, next_shuffled()};
    span = r.hi - r.lo + 32'd1;
    if (span == 32'd0) return r.lo;
    limit = 32'h7FFF_FFFF - (32'h8000_0000 % span);
    do n = {1'b0, next_shuffled()}; while (n > limit);
    return r.lo + n % span;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic draw_req_t rand_req();
    draw_req_t r;
    r.kind = 1'($urandom_range(0, 1));
    r.lo = $urandom;
    case ($urandom_range(0, 9))
      0: r.hi = r.lo - 32'd1;
      1, 2, 3: r.hi = r.lo + $urandom_range(0, 99);
      // span just above 2^30: about half the draws get rejected
      4: r.hi = r.lo + 32'h4000_0000 + $urandom_range(0, 255);
      default: r.hi = $urandom;
    endcase
    return r;
  endfunction

  function automatic void add_req(logic k, logic [31:0] lo, logic [31:0] hi);
    draw_req_t r;
    r.kind = k;
    r.lo = lo;
    r.hi = hi;
    pending_reqs.push_back(r);
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_valid || expected_values.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_seed(input logic [30:0] v);
    @(negedge clk);
    seed_valid <= 1'b1;
    seed_word <= v;
    do @(posedge clk); while (!seed_ready);
    gen_seed = v;
    gen_reseed = 1'b1;
    @(negedge clk);
    seed_valid <= 1'b0;
  endtask

  // request driver
  always @(negedge clk) begin : drive_req
    draw_req_t r;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_went) begin
      // hold the stalled beat
    end else if (tx_gap > 0) begin
      req_valid <= 1'b0;
      tx_gap <= tx_gap - 1;
    end else if (pending_reqs.size() != 0) begin
      r = pending_reqs.pop_front();
      kind <= r.kind;
      range_low <= r.lo;
      range_high <= r.hi;
      req_valid <= 1'b1;
      tx_gap <= tx_idle_on ? pick_gap() : 0;
    end else begin
      req_valid <= 1'b0;
    end
  end

  // response stall: short random stalls, and one long hold-off once HOLD_AT beats are in
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && beats_in >= HOLD_AT) begin
      rsp_stall <= 1'b1;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (rx_gap > 0) begin
      rsp_stall <= 1'b1;
      rx_gap <= rx_gap - 1;
    end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
      rsp_stall <= 1'b1;
      rx_gap <= pick_gap();
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // check results, then predict for the request beat taken at this edge
  always @(posedge clk) begin : track_beats
    logic [31:0] want;
    draw_req_t   cur;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_values.size() == 0) begin
        $display("%0t: result %h with nothing expected", $time, value);
        errors++;
      end else begin
        want = expected_values.pop_front();
        if (value !== want) begin
          $display("%0t: value mismatch, expected %h, got %h", $time, want, value);
          errors++;
        end
      end
    end
    if (!rst && req_valid && !req_stall) begin
      cur.kind = kind;
      cur.lo = range_low;
      cur.hi = range_high;
      expected_values.push_back(predict_value(cur));
      beats_in <= beats_in + 1;
    end
    req_went <= !rst && req_valid && !req_stall;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero span first: no draw, warm-up stays armed
    add_req(KIND_RANGE, 32'd5, 32'd4);
    add_req(KIND_RAW, 32'd0, 32'd0);
    add_req(KIND_RAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(KIND_RANGE, 32'd0, 32'hFFFF_FFFF);
    add_req(KIND_RANGE, 32'h8000_0000, 32'h7FFF_FFFF);
    add_req(KIND_RANGE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_req(KIND_RANGE, 32'h8000_0000, 32'h8000_0000);
    add_req(KIND_RANGE, 32'd0, 32'd0);
    add_req(KIND_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(KIND_RANGE, 32'd0, 32'h7FFF_FFFF);
    add_req(KIND_RANGE, 32'h8000_0000, 32'd0);
    add_req(KIND_RANGE, 32'h8000_0001, 32'h7FFF_FFFF);
    add_req(KIND_RANGE, 32'd1, 32'd6);
    add_req(KIND_RANGE, -32'sd10, 32'sd10);
    // reversed bounds wrap the span
    add_req(KIND_RANGE, 32'sd100, -32'sd100);
    add_req(KIND_RANGE, 32'h7FFF_FFFF, 32'h8000_0000);
    add_req(KIND_RANGE, 32'h7FFF_FFF0, 32'h8000_000F);
    add_req(KIND_RANGE, 32'd0, 32'h4000_0000);
    add_req(KIND_RANGE, 32'hC000_0000, 32'd0);
    add_req(KIND_RANGE, 32'd0, 32'h7FFF_FFFE);
    add_req(KIND_RAW, 32'h5A5A_5A5A, 32'hA5A5_A5A5);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      tx_idle_on = (p != 3);
      rx_idle_on = (p != 3);
      case (p)
        0: write_seed(31'h7FFF_FFFF);
        1: write_seed(31'h7FFF_FFFE);
        2: write_seed(31'd1);
        3: write_seed(31'($urandom_range(2, 32'h7FFF_FFFD)));
        5: write_seed(31'd0);
        default: ;
      endcase
      @(posedge clk);
      repeat (PHASE_LEN) pending_reqs.push_back(rand_req());
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("shuffled_lcg_random_range_tb OK");
    else
      $display("shuffled_lcg_random_range_tb NOT OK");
    $finish;
  end

  initial begin
    #20000000;
    $display("%0t: timeout", $time);
    $display("shuffled_lcg_random_range_tb NOT OK");
    $finish;
  end

endmodule
